// ===== rtl/address_range_blocklist_unit_assert.svh =====
// Assertion macros shared by the address range blocklist RTL.
`ifndef ADDRESS_RANGE_BLOCKLIST_UNIT_ASSERT_SVH
`define ADDRESS_RANGE_BLOCKLIST_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define ARBL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
// Next-cycle implication.
`define ARBL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");
`else
`define ARBL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ARBL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/arbl_pkg.sv =====
// Types, constants and helpers of the address range blocklist.
package arbl_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int ADDR_WIDTH  = 64;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_PRIVILEGED_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_USER_LIMIT      = 1'b1;
   localparam logic [63:0] USER_LIMIT_RESET = 64'h0000_7FFF_FFFF_F000;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [CNT_W-1:0]      count_type;

   typedef enum logic {
      OP_CHECK  = 1'b0,
      OP_INSERT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_LIMIT    = 3'd2,
      ST_BLOCKED  = 3'd3,
      ST_CONFLICT = 3'd4,
      ST_FULL     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_PREP,
      CS_LAUNCH,
      CS_SCAN,
      CS_FINISH
   } ctrl_state_type;

   typedef struct packed {
      op_type      operation;
      logic [63:0] addr;
      logic [63:0] length;
      logic [63:0] end_addr;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        bad;
      logic        min_hit;
      logic [3:0]  min_index;
      logic        max_hit;
      logic [3:0]  max_index;
      logic [4:0]  entry_total;
   } rsp_type;

   // One stored range [rng_start, rng_end).
   typedef struct packed {
      addr_type rng_start;
      addr_type rng_end;
   } entry_type;

   // Request walking the cell row with its partial results.
   typedef struct packed {
      logic      valid;
      op_type    op;
      addr_type  lo;
      addr_type  key;
      count_type left;
      count_type idx;
      logic      blocked;
      logic      min_hit;
      count_type min_idx;
      logic      max_hit;
      count_type max_idx;
      logic      ins_found;
      count_type ins_pos;
   } token_type;

   // Table update broadcast to every cell.
   typedef struct packed {
      logic      en;
      count_type pos;
      entry_type entry;
   } commit_type;

   // Truncate a table index to the result's index field.
   function automatic logic [3:0] idx_field(input count_type v);
      logic [31:0] w;
      w = 32'(v);
      return w[3:0];
   endfunction

   // Truncate an entry count to the result's total field.
   function automatic logic [4:0] total_field(input count_type v);
      logic [31:0] w;
      w = 32'(v);
      return w[4:0];
   endfunction

endpackage

// ===== rtl/arbl_cell.sv =====
// One table cell: holds one range, updates the passing request, shifts on insert.
module arbl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  arbl_pkg::count_type    cell_id,
   input  arbl_pkg::token_type    up_token,
   output arbl_pkg::token_type    down_token,
   input  arbl_pkg::entry_type    left_entry,
   output arbl_pkg::entry_type    entry,
   input  arbl_pkg::commit_type   commit
);

   arbl_pkg::token_type tok_ff;
   arbl_pkg::token_type tok_in;
   arbl_pkg::entry_type entry_ff;
   arbl_pkg::entry_type entry_in;

   logic live;
   logic lo_inside;
   logic key_inside;
   logic overlap;
   logic lo_before;

   // Compare the request against this cell's range
   always_comb begin
      live       = up_token.left != '0;
      lo_inside  = live && (entry_ff.rng_start <= up_token.lo)
                        && (up_token.lo < entry_ff.rng_end);
      key_inside = live && (entry_ff.rng_start <= up_token.key)
                        && (up_token.key < entry_ff.rng_end);
      overlap    = live && (up_token.lo < entry_ff.rng_end)
                        && (up_token.key >= entry_ff.rng_start);
      lo_before  = live && (up_token.lo < entry_ff.rng_start);
   end

   // Fold this cell's findings into the request and hand it on
   always_comb begin
      tok_in      = up_token;
      tok_in.left = up_token.left - arbl_pkg::count_type'(live);
      tok_in.idx  = up_token.idx + arbl_pkg::count_type'(1'b1);
      if (up_token.op == arbl_pkg::OP_CHECK) begin
         tok_in.blocked = up_token.blocked | overlap;
      end else begin
         if (lo_inside && !up_token.min_hit) begin
            tok_in.min_hit = 1'b1;
            tok_in.min_idx = up_token.idx;
         end
         if (key_inside && !up_token.max_hit) begin
            tok_in.max_hit = 1'b1;
            tok_in.max_idx = up_token.idx;
         end
         if (lo_before && !up_token.ins_found) begin
            tok_in.ins_found = 1'b1;
            tok_in.ins_pos   = up_token.idx;
         end
      end
   end

   // Take the new range at the insert point, shift right behind it
   always_comb begin
      entry_in = entry_ff;
      if (commit.en) begin
         if (cell_id == commit.pos) begin
            entry_in = commit.entry;
         end else if (cell_id > commit.pos) begin
            entry_in = left_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign down_token = tok_ff;
   assign entry      = entry_ff;

endmodule

// ===== rtl/arbl_ctrl.sv =====
// Sequencer: request intake, range precheck, configuration, result register.
`include "address_range_blocklist_unit_assert.svh"
module arbl_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  arbl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output arbl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [arbl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arbl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output arbl_pkg::token_type               head_token,
   input  arbl_pkg::token_type               tail_token,
   output arbl_pkg::commit_type              commit
);

   arbl_pkg::ctrl_state_type state_ff, state_in;

   logic                 priv_ff;
   arbl_pkg::addr_type   limit_ff;
   arbl_pkg::count_type  count_ff, count_in;

   arbl_pkg::op_type     op_ff;
   arbl_pkg::addr_type   addr_ff;
   arbl_pkg::addr_type   len_ff;
   arbl_pkg::addr_type   end_ff;
   arbl_pkg::addr_type   lenm1_ff;
   arbl_pkg::addr_type   last_ff;
   logic                 invalid_ff;
   arbl_pkg::token_type  res_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   arbl_pkg::rsp_type    rsp_ff;
   arbl_pkg::rsp_type    rsp_new;

   logic                 accept;
   logic                 load;
   logic                 limit_hit;
   logic                 conflict;
   logic                 full;

   assign accept = req_valid && !req_stall;
   assign load   = (state_ff == arbl_pkg::CS_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // Sequence one request through precheck, cell walk and result
   always_comb begin
      state_in  = state_ff;
      req_stall = state_ff != arbl_pkg::CS_IDLE;
      unique case (state_ff)
         arbl_pkg::CS_IDLE:   if (req_valid) state_in = arbl_pkg::CS_PREP;
         arbl_pkg::CS_PREP:   state_in = arbl_pkg::CS_LAUNCH;
         arbl_pkg::CS_LAUNCH: state_in = arbl_pkg::CS_SCAN;
         arbl_pkg::CS_SCAN:   if (tail_token.valid) state_in = arbl_pkg::CS_FINISH;
         arbl_pkg::CS_FINISH: if (load) state_in = arbl_pkg::CS_IDLE;
         default:             state_in = arbl_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arbl_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         priv_ff  <= 1'b0;
         limit_ff <= arbl_pkg::USER_LIMIT_RESET[arbl_pkg::ADDR_WIDTH-1:0];
      end else if (csr_write) begin
         unique case (csr_index)
            arbl_pkg::CSR_PRIVILEGED_MODE: priv_ff  <= csr_wdata[0];
            arbl_pkg::CSR_USER_LIMIT:      limit_ff <= csr_wdata[arbl_pkg::ADDR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Capture the request, then work out its last byte and range validity
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_data.operation;
         addr_ff <= req_data.addr[arbl_pkg::ADDR_WIDTH-1:0];
         len_ff  <= req_data.length[arbl_pkg::ADDR_WIDTH-1:0];
         end_ff  <= req_data.end_addr[arbl_pkg::ADDR_WIDTH-1:0];
      end
      if (state_ff == arbl_pkg::CS_PREP) begin
         lenm1_ff <= len_ff - arbl_pkg::addr_type'(1'b1);
         last_ff  <= addr_ff + len_ff - arbl_pkg::addr_type'(1'b1);
      end
      if (state_ff == arbl_pkg::CS_LAUNCH) begin
         invalid_ff <= (len_ff == '0) || ((~addr_ff) < lenm1_ff);
      end
      if (tail_token.valid) begin
         res_ff <= tail_token;
      end
   end

   // Launch the request into the first cell
   always_comb begin
      head_token           = '0;
      head_token.valid     = state_ff == arbl_pkg::CS_LAUNCH;
      head_token.op        = op_ff;
      head_token.lo        = addr_ff;
      head_token.key       = (op_ff == arbl_pkg::OP_INSERT) ? end_ff : last_ff;
      head_token.left      = count_ff;
   end

   // Build the result and the table update
   always_comb begin
      limit_hit = !priv_ff && (last_ff >= limit_ff);
      conflict  = res_ff.min_hit || res_ff.max_hit;
      full      = count_ff >= arbl_pkg::count_type'(arbl_pkg::TABLE_DEPTH);

      commit.en    = load && (op_ff == arbl_pkg::OP_INSERT) && !conflict && !full;
      commit.pos   = res_ff.ins_found ? res_ff.ins_pos : count_ff;
      commit.entry = '{rng_start: addr_ff, rng_end: end_ff};

      count_in = count_ff + arbl_pkg::count_type'(commit.en);

      rsp_new             = '0;
      rsp_new.entry_total = arbl_pkg::total_field(count_in);
      if (op_ff == arbl_pkg::OP_CHECK) begin
         if (invalid_ff) begin
            rsp_new.status = arbl_pkg::ST_INVALID;
         end else if (limit_hit) begin
            rsp_new.status = arbl_pkg::ST_LIMIT;
         end else if (res_ff.blocked) begin
            rsp_new.status = arbl_pkg::ST_BLOCKED;
         end else begin
            rsp_new.status = arbl_pkg::ST_OK;
         end
         rsp_new.bad = rsp_new.status != arbl_pkg::ST_OK;
      end else if (conflict) begin
         rsp_new.status    = arbl_pkg::ST_CONFLICT;
         rsp_new.min_hit   = res_ff.min_hit;
         rsp_new.min_index = res_ff.min_hit ? arbl_pkg::idx_field(res_ff.min_idx) : 4'd0;
         rsp_new.max_hit   = res_ff.max_hit;
         rsp_new.max_index = res_ff.max_hit ? arbl_pkg::idx_field(res_ff.max_idx) : 4'd0;
      end else if (full) begin
         rsp_new.status = arbl_pkg::ST_FULL;
      end else begin
         rsp_new.status = arbl_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Output register: hold while stalled, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_new;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ARBL_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1,
      count_ff <= arbl_pkg::count_type'(arbl_pkg::TABLE_DEPTH))
   `ARBL_ASSERT_IMPL(a_commit_room, clock, reset, commit.en,
      !full && op_ff == arbl_pkg::OP_INSERT)
   `ARBL_ASSERT_IMPL(a_tail_in_scan, clock, reset, tail_token.valid,
      state_ff == arbl_pkg::CS_SCAN)
   `ARBL_ASSERT_NEXT(a_accept_prep, clock, reset, accept,
      state_ff == arbl_pkg::CS_PREP)

endmodule

// ===== rtl/address_range_blocklist_unit.sv =====
// Top level of the address range blocklist: sequencer and row of table cells.
//
// Keeps up to TABLE_DEPTH half-open ranges sorted by start, one range per cell.
// A request is taken only while the block is idle and walks the cell row one
// cell per clock. After acceptance it forms its last byte, is launched into the
// first cell and crosses the cell row; its result is then loaded into the
// output register. The block is idle again in the cycle after the load, so it
// takes no new request until the last one is through. A stalled result holds
// the next acceptance until the result register frees. Inserts update the table
// in the load cycle by shifting every cell behind the insert point one place
// right. The stored ranges come up undefined; only the entries counted as
// filled are ever consulted.
`include "address_range_blocklist_unit_assert.svh"
module address_range_blocklist_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  arbl_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output arbl_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [arbl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [arbl_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   arbl_pkg::token_type  tok [0:arbl_pkg::TABLE_DEPTH];
   arbl_pkg::entry_type  ent [0:arbl_pkg::TABLE_DEPTH];
   arbl_pkg::commit_type commit;
   logic [arbl_pkg::TABLE_DEPTH:0] tok_valid;

   arbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_token (tok[0]),
      .tail_token (tok[arbl_pkg::TABLE_DEPTH]),
      .commit     (commit)
   );

   // Nothing shifts into the first cell
   assign ent[0] = '0;

   // Row of table cells
   for (genvar g = 0; g < arbl_pkg::TABLE_DEPTH; g++) begin : g_cell
      arbl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (arbl_pkg::count_type'(g)),
         .up_token   (tok[g]),
         .down_token (tok[g+1]),
         .left_entry (ent[g]),
         .entry      (ent[g+1]),
         .commit     (commit)
      );
   end

   for (genvar v = 0; v <= arbl_pkg::TABLE_DEPTH; v++) begin : g_valid
      assign tok_valid[v] = tok[v].valid;
   end

   `ARBL_ASSERT_IMPL(a_one_request, clock, reset, 1'b1, $onehot0(tok_valid))

endmodule
